@@ hw/rtl/tmet_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmet_pkg
// Types, codes and helpers shared by the mouse escape translator.
// ----------------------------------------------------------------------------
package tmet_pkg;

	localparam int PendDepth = 6;
	localparam int QueueDepth = 4;
	localparam int QueuePtrW = $clog2(QueueDepth);

	localparam logic [7:0] EscCode = 8'd27;
	localparam logic [7:0] ChLbrack = 8'h5b;
	localparam logic [7:0] ChM = 8'h4d;
	localparam logic [7:0] ChSemi = 8'h3b;
	localparam logic [7:0] ChOne = 8'h31;
	localparam logic [7:0] ChT = 8'h74;
	localparam logic [7:0] ChMinus = 8'h2d;
	localparam logic [7:0] ChZero = 8'h30;
	localparam logic [7:0] BtnOffset = 8'd32;
	localparam logic [8:0] PosOffset = 9'd33;
	localparam logic [15:0] TimeoutReset = 16'd200;
	localparam logic [15:0] ElapsedMax = 16'hffff;

	localparam logic [8:0] KindPress = 9'd31;
	localparam logic [8:0] KindRelease = 9'd32;
	localparam logic [8:0] KindMotion = 9'd33;

	typedef struct packed {
		logic       command;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} out_item_t;

	// token between sequencer and formatter: a byte or a signed decimal
	typedef struct packed {
		logic       is_dec;
		logic       last;
		logic [8:0] val;
	} tok_t;

	typedef enum logic [1:0] {
		PARSE_REC,
		PARSE_UNK,
		PARSE_INC
	} parse_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_SCAN,
		F_REPORT
	} front_state_t;

	typedef struct packed {
		logic [3:0][7:0] chars;
		logic [2:0]      len;
	} dec_t;

	// split a signed value of small magnitude into ascii characters
	function automatic dec_t dec_split(logic [8:0] v);
		dec_t       d;
		logic [7:0] u;
		logic [7:0] r;
		logic [3:0] h;
		logic [3:0] t;
		logic [7:0] o;
		logic [2:0] k;
		u = v[8] ? 8'(-v) : v[7:0];
		if (u >= 8'd200) begin
			h = 4'd2;
			r = u - 8'd200;
		end else if (u >= 8'd100) begin
			h = 4'd1;
			r = u - 8'd100;
		end else begin
			h = 4'd0;
			r = u;
		end
		t = 4'd0;
		for (int i = 1; i < 10; i++) begin
			if (r >= 8'(i * 10)) t = 4'(i);
		end
		o = r - 8'({4'd0, t} * 8'd10);
		d.chars = '0;
		k = 3'd0;
		if (v[8]) begin
			d.chars[k[1:0]] = ChMinus;
			k = k + 3'd1;
		end
		if (u >= 8'd100) begin
			d.chars[k[1:0]] = ChZero + {4'd0, h};
			k = k + 3'd1;
		end
		if (u >= 8'd10) begin
			d.chars[k[1:0]] = ChZero + {4'd0, t};
			k = k + 3'd1;
		end
		d.chars[k[1:0]] = ChZero + o;
		d.len = k + 3'd1;
		return d;
	endfunction

endpackage

@@ hw/rtl/tmet_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmet_queue
// Short token queue between the sequencer and the formatter.
// ----------------------------------------------------------------------------
module tmet_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tmet_pkg::tok_t  wdata,
	output logic            full,
	input  logic            pop,
	output tmet_pkg::tok_t  rdata,
	output logic            empty
);
	import tmet_pkg::*;

	tok_t                 mem_q [QueueDepth];
	logic [QueuePtrW-1:0] wptr_q;
	logic [QueuePtrW-1:0] rptr_q;
	logic [QueuePtrW:0]   count_q;

	assign full = (count_q == (QueuePtrW + 1)'(QueueDepth));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= wdata;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop) rptr_q <= rptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

@@ hw/rtl/tmet_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmet_front
// Accepts bytes and ticks, keeps the pending sequence and emits tokens.
// ----------------------------------------------------------------------------
module tmet_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  tmet_pkg::in_item_t in_data,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata,
	output logic               q_push,
	output tmet_pkg::tok_t     q_wdata,
	input  logic               q_full
);
	import tmet_pkg::*;

	front_state_t state_q, state_d;
	logic [7:0]  pend_q [PendDepth];
	logic [2:0]  cnt_q;
	logic        wait_q;
	logic [15:0] elapsed_q;
	logic [2:0]  held_q;
	logic [15:0] timeout_q;
	logic [3:0]  step_q;
	logic        hold_v_q;
	tok_t        hold_q;

	parse_t      parse;
	logic        emit_ok;
	logic        emit;
	tok_t        emit_tok;
	logic        shift1;
	logic        fin;
	logic        set_wait;
	logic        clr_wait;
	logic        rep_start;
	logic        rep_done;
	logic        accept;

	logic [7:0]  b;
	logic        motion;
	logic        release_k;
	logic        press;
	logic [2:0]  btn;
	logic [8:0]  kind;

	assign accept = in_valid && in_ready;
	assign emit_ok = !hold_v_q || !q_full;

	// classify the pending sequence
	always_comb begin
		if (cnt_q < 3'd2) parse = PARSE_INC;
		else if (pend_q[1] != ChLbrack) parse = PARSE_UNK;
		else if (cnt_q < 3'd3) parse = PARSE_INC;
		else if (pend_q[2] != ChM) parse = PARSE_UNK;
		else if (cnt_q < 3'd6) parse = PARSE_INC;
		else parse = PARSE_REC;
	end

	// mouse report fields
	assign b = pend_q[3] - BtnOffset;
	assign motion = b[5];
	assign release_k = !b[5] && (b[1:0] == 2'd3);
	assign press = !motion && !release_k;
	assign btn = 3'd4 >> b[1:0];
	assign kind = motion ? KindMotion : (release_k ? KindRelease : KindPress);

	// actions
	always_comb begin
		in_ready = 1'b0;
		emit = 1'b0;
		emit_tok = '0;
		shift1 = 1'b0;
		fin = 1'b0;
		set_wait = 1'b0;
		clr_wait = 1'b0;
		rep_start = 1'b0;
		rep_done = 1'b0;
		unique case (state_q)
			F_IDLE: in_ready = 1'b1;
			F_SCAN: begin
				if (cnt_q == 3'd0) begin
					fin = emit_ok;
				end else if (pend_q[0] != EscCode) begin
					emit = emit_ok;
					emit_tok = '{is_dec: 1'b0, last: 1'b0, val: {1'b0, pend_q[0]}};
					shift1 = emit_ok;
				end else begin
					priority case (parse)
						PARSE_REC: rep_start = 1'b1;
						PARSE_UNK: begin
							emit = emit_ok;
							emit_tok = '{is_dec: 1'b0, last: 1'b0, val: {1'b0, EscCode}};
							shift1 = emit_ok;
							clr_wait = emit_ok;
						end
						default: begin
							if (!wait_q) begin
								set_wait = 1'b1;
							end else if (elapsed_q >= timeout_q) begin
								emit = emit_ok;
								emit_tok = '{is_dec: 1'b0, last: 1'b0, val: {1'b0, EscCode}};
								shift1 = emit_ok;
								clr_wait = emit_ok;
							end else begin
								fin = emit_ok;
							end
						end
					endcase
				end
			end
			F_REPORT: begin
				emit = emit_ok;
				emit_tok.last = 1'b0;
				unique case (step_q)
					4'd0: emit_tok = '{1'b0, 1'b0, {1'b0, EscCode}};
					4'd1: emit_tok = '{1'b0, 1'b0, {1'b0, ChLbrack}};
					4'd2: emit_tok = '{1'b1, 1'b0, kind};
					4'd4: emit_tok = '{1'b1, 1'b0, {1'b0, pend_q[5]} - PosOffset};
					4'd6: emit_tok = '{1'b1, 1'b0, {1'b0, pend_q[4]} - PosOffset};
					4'd3, 4'd5, 4'd7: emit_tok = '{1'b0, 1'b0, {1'b0, ChSemi}};
					4'd8: emit_tok = '{1'b1, 1'b0, {6'd0, press ? btn : held_q}};
					4'd9: emit_tok = '{1'b0, 1'b0, {1'b0, press ? ChSemi : ChT}};
					4'd10: emit_tok = '{1'b0, 1'b0, {1'b0, ChOne}};
					default: emit_tok = '{1'b0, 1'b0, {1'b0, ChT}};
				endcase
				rep_done = emit_ok && ((!press && step_q == 4'd9) || step_q == 4'd11);
			end
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE: if (accept) state_d = F_SCAN;
			F_SCAN: begin
				if (fin) state_d = F_IDLE;
				else if (rep_start) state_d = F_REPORT;
			end
			F_REPORT: if (rep_done) state_d = F_SCAN;
			default: state_d = F_IDLE;
		endcase
	end

	// token handoff, last token is held until the item is finished
	always_comb begin
		q_push = hold_v_q && (emit || fin);
		q_wdata = hold_q;
		q_wdata.last = fin;
	end

	// pending bytes
	always_ff @(posedge clk) begin
		if (accept && !in_data.command) begin
			pend_q[cnt_q] <= in_data.data_byte;
		end else if (shift1) begin
			for (int i = 0; i < PendDepth - 1; i++) pend_q[i] <= pend_q[i + 1];
		end
	end

	// holding token
	always_ff @(posedge clk) begin
		if (emit) hold_q <= emit_tok;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q <= '0;
			wait_q <= 1'b0;
			elapsed_q <= '0;
			held_q <= '0;
			timeout_q <= TimeoutReset;
			step_q <= '0;
			hold_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) timeout_q <= cfg_wdata;
			if (accept) begin
				if (in_data.command) begin
					if (wait_q && elapsed_q != ElapsedMax) elapsed_q <= elapsed_q + 16'd1;
				end else begin
					cnt_q <= cnt_q + 3'd1;
				end
			end
			if (shift1) cnt_q <= cnt_q - 3'd1;
			if (set_wait) begin
				wait_q <= 1'b1;
				elapsed_q <= '0;
			end
			if (clr_wait) wait_q <= 1'b0;
			if (rep_start) step_q <= '0;
			else if (emit && state_q == F_REPORT) step_q <= step_q + 4'd1;
			if (rep_done) begin
				cnt_q <= '0;
				wait_q <= 1'b0;
				if (press) held_q <= held_q | btn;
				else if (release_k) held_q <= '0;
			end
			if (emit) hold_v_q <= 1'b1;
			else if (fin) hold_v_q <= 1'b0;
		end
	end

endmodule

@@ hw/rtl/tmet_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmet_back
// Expands tokens into output bytes and drives the output register.
// ----------------------------------------------------------------------------
module tmet_back (
	input  logic                clk,
	input  logic                arst_n,
	output logic                q_pop,
	input  tmet_pkg::tok_t      q_rdata,
	input  logic                q_empty,
	output logic                out_valid,
	input  logic                out_ready,
	output tmet_pkg::out_item_t out_data
);
	import tmet_pkg::*;

	logic            cur_v_q;
	logic [3:0][7:0] chars_q;
	logic [2:0]      len_q;
	logic [1:0]      idx_q;
	logic            last_q;
	logic            out_v_q;
	out_item_t       out_q;

	dec_t            dec;
	logic            advance;
	logic            final_char;

	assign dec = dec_split(q_rdata.val);
	assign advance = !out_v_q || out_ready;
	assign final_char = ({1'b0, idx_q} + 3'd1) == len_q;
	assign q_pop = !cur_v_q && !q_empty;
	assign out_valid = out_v_q;
	assign out_data = out_q;

	// token expansion registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			if (q_rdata.is_dec) begin
				chars_q <= dec.chars;
				len_q <= dec.len;
			end else begin
				chars_q <= {24'd0, q_rdata.val[7:0]};
				len_q <= 3'd1;
			end
			last_q <= q_rdata.last;
		end
		if (advance && cur_v_q) begin
			out_q.out_byte <= chars_q[idx_q];
			out_q.last <= last_q && final_char;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q <= 1'b0;
			idx_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (q_pop) begin
				cur_v_q <= 1'b1;
				idx_q <= '0;
			end else if (advance && cur_v_q) begin
				idx_q <= idx_q + 2'd1;
				if (final_char) cur_v_q <= 1'b0;
			end
			if (advance) out_v_q <= cur_v_q;
		end
	end

endmodule

@@ hw/rtl/terminal_mouse_escape_translator_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terminal_mouse_escape_translator_top
// Translates xterm X10 mouse reports in a terminal byte stream to text.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries a byte or a tick; output channel
// out_valid/out_ready carries translated bytes, last marking the final byte
// caused by one input transfer. cfg_we/cfg_wdata set the escape timeout.
// The sequencer takes one input transfer while idle and works through the
// pending bytes at one decision per cycle while the queue has room, pushing
// tokens (a byte or a decimal number) into a four-entry queue. The formatter
// pops a token, then sends its bytes one per cycle while the receiver is
// ready, through a registered output stage, and pops the next token only
// after the last byte of the current one has been sent. A mouse report
// yields up to 17 bytes in 12 tokens.
// Reset clears the pending sequence and held buttons and sets the timeout to 200 ticks.
// When the receiver stalls the output stage holds, the queue fills and the
// sequencer waits; input is refused until the current item is finished.
// ----------------------------------------------------------------------------
module terminal_mouse_escape_translator_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tmet_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output tmet_pkg::out_item_t out_data,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_wdata
);
	import tmet_pkg::*;

	logic q_push;
	tok_t q_wdata;
	logic q_full;
	logic q_pop;
	tok_t q_rdata;
	logic q_empty;

	// sequencer
	tmet_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_push    (q_push),
		.q_wdata   (q_wdata),
		.q_full    (q_full)
	);

	// token queue
	tmet_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	// formatter
	tmet_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_pop     (q_pop),
		.q_rdata   (q_rdata),
		.q_empty   (q_empty),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the mouse escape translator against an in-bench byte-stream model.
// Directed items cover pass-through, unknown and short sequences, every report
// kind, negative positions and timeouts; random items mix well-formed mouse
// reports with noise under several idling phases and timeout settings.
// ----------------------------------------------------------------------------
module tb_top;
	import tmet_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_data;
	logic        cfg_we;
	logic [15:0] cfg_wdata;

	terminal_mouse_escape_translator_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	// predictor state
	logic [7:0]  seq_buf [PendDepth];
	int          seq_len;
	bit          seq_waiting;
	logic [15:0] seq_ticks;
	logic [2:0]  buttons;
	logic [15:0] timeout_ticks;
	out_item_t   expected_bytes [$];
	logic [7:0]  emit_buf [$];

	int errors;
	int n_items;
	int n_reports;
	int send_idle_pct;
	int recv_stall_pct;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("tb_top: errors");
		$finish;
	end

	function automatic void emit(logic [7:0] b);
		emit_buf.push_back(b);
	endfunction

	function automatic void drop_front(int n);
		if (n > seq_len) n = seq_len;
		for (int i = n; i < seq_len; i++) seq_buf[i - n] = seq_buf[i];
		seq_len -= n;
	endfunction

	function automatic void flush_front(int n);
		if (n > seq_len) n = seq_len;
		for (int i = 0; i < n; i++) emit(seq_buf[i]);
		drop_front(n);
	endfunction

	function automatic void emit_decimal(int v);
		int u;
		u = v;
		if (v < 0) begin
			emit(ChMinus);
			u = -v;
		end
		if (u >= 100) emit(8'(48 + (u / 100) % 10));
		if (u >= 10) emit(8'(48 + (u / 10) % 10));
		emit(8'(48 + u % 10));
	endfunction

	// 0 recognized, 1 unknown, 2 incomplete
	function automatic int decode_report();
		logic [7:0] b;
		logic [2:0] btn;
		int kind;
		if (seq_len < 2) return 2;
		if (seq_buf[1] != ChLbrack) return 1;
		if (seq_len < 3) return 2;
		if (seq_buf[2] != ChM) return 1;
		if (seq_len < 6) return 2;
		b = seq_buf[3] - BtnOffset;
		if (b[5]) kind = KindMotion;
		else if (b[1:0] == 2'b11) kind = KindRelease;
		else kind = KindPress;
		emit(EscCode);
		emit(ChLbrack);
		emit_decimal(kind);
		emit(ChSemi);
		emit_decimal(int'(seq_buf[5]) - 33);
		emit(ChSemi);
		emit_decimal(int'(seq_buf[4]) - 33);
		emit(ChSemi);
		if (kind == KindPress) begin
			btn = 3'd4 >> b[1:0];
			buttons = buttons | btn;
			emit_decimal(btn);
			emit(ChSemi);
			emit(ChOne);
		end else begin
			emit_decimal(buttons);
			if (kind == KindRelease) buttons = 3'd0;
		end
		emit(ChT);
		drop_front(6);
		return 0;
	endfunction

	function automatic void predict_item(in_item_t it);
		int i;
		int r;
		emit_buf.delete();
		if (it.command) begin
			if (seq_waiting && seq_ticks != ElapsedMax) seq_ticks++;
		end else if (seq_len < PendDepth) begin
			seq_buf[seq_len] = it.data_byte;
			seq_len++;
		end else begin
			emit(it.data_byte);
		end
		forever begin
			i = 0;
			while (i < seq_len && seq_buf[i] != EscCode) i++;
			flush_front(i);
			if (seq_len == 0) break;
			r = decode_report();
			if (r == 0) begin
				seq_waiting = 0;
				n_reports++;
			end else if (r == 1) begin
				seq_waiting = 0;
				flush_front(1);
			end else if (seq_waiting) begin
				if (seq_ticks >= timeout_ticks) begin
					flush_front(1);
					seq_waiting = 0;
				end else break;
			end else begin
				seq_waiting = 1;
				seq_ticks = 0;
			end
		end
		while (emit_buf.size() > 17) void'(emit_buf.pop_back());
		foreach (emit_buf[k]) begin
			out_item_t o;
			o.out_byte = emit_buf[k];
			o.last = (k == emit_buf.size() - 1);
			expected_bytes.push_back(o);
		end
	endfunction

	// one input transfer, valid stays up until the sender idles or waits
	task automatic send_item(input logic cmd, input logic [7:0] data);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data.command <= cmd;
		in_data.data_byte <= data;
		do @(posedge clk); while (!in_ready);
		predict_item({cmd, data});
		n_items++;
		@(negedge clk);
	endtask

	task automatic send_byte(input logic [7:0] data);
		send_item(1'b0, data);
	endtask

	task automatic send_tick();
		send_item(1'b1, 8'($urandom));
	endtask

	task automatic send_report(input logic [7:0] b, input logic [7:0] x, input logic [7:0] y);
		send_byte(EscCode);
		send_byte(ChLbrack);
		send_byte(ChM);
		send_byte(b);
		send_byte(x);
		send_byte(y);
	endtask

	// wait for the block to drain, then set the timeout
	task automatic drain_and_set_timeout(input logic [15:0] v);
		int guard;
		in_valid <= 1'b0;
		guard = 0;
		while (expected_bytes.size() != 0 && guard < 200000) begin
			@(negedge clk);
			guard++;
		end
		repeat (40) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		timeout_ticks = v;
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_bytes.size() == 0) begin
				$error("unexpected output byte %0h", out_data.out_byte);
				errors++;
			end else begin
				out_item_t e;
				e = expected_bytes.pop_front();
				if (out_data.out_byte !== e.out_byte) begin
					$error("out_byte expected %0h actual %0h", e.out_byte, out_data.out_byte);
					errors++;
				end
				if (out_data.last !== e.last) begin
					$error("last expected %0b actual %0b", e.last, out_data.last);
					errors++;
				end
			end
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		out_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
	end

	task automatic test_plain_bytes();
		send_byte(8'h00);
		send_byte(8'hff);
		send_byte(8'h41);
		send_tick();
	endtask

	task automatic test_unknown_sequences();
		send_byte(EscCode);
		send_byte(8'h41);
		send_byte(EscCode);
		send_byte(ChLbrack);
		send_byte(8'h42);
		send_byte(EscCode);
		send_byte(EscCode);
		send_byte(8'h43);
	endtask

	task automatic test_reports();
		send_report(8'd32, 8'd34, 8'd35);
		send_report(8'd33, 8'd255, 8'd0);
		send_report(8'd64, 8'd0, 8'd255);
		send_report(8'd35, 8'd33, 8'd33);
		send_report(8'd34, 8'd100, 8'd200);
		send_report(8'd31, 8'd1, 8'd2);
	endtask

	task automatic test_short_and_timeout();
		drain_and_set_timeout(16'd3);
		send_byte(EscCode);
		send_byte(ChLbrack);
		send_byte(ChM);
		repeat (4) send_tick();
		send_byte(8'h20);
		drain_and_set_timeout(16'd0);
		send_byte(EscCode);
		send_byte(8'h5a);
		drain_and_set_timeout(16'hffff);
		send_byte(EscCode);
		send_byte(ChLbrack);
		send_byte(ChM);
		send_byte(8'h20);
		send_byte(8'h21);
		send_byte(8'h22);
		send_byte(8'h23);
	endtask

	task automatic test_random(input int count, input logic [15:0] tmo);
		int k;
		drain_and_set_timeout(tmo);
		k = 0;
		while (k < count) begin
			int sel;
			sel = $urandom_range(9);
			if (sel < 5) begin
				send_report(8'($urandom), 8'($urandom), 8'($urandom));
				k += 6;
			end else if (sel < 7) begin
				send_byte(EscCode);
				if ($urandom_range(1)) send_byte(ChLbrack);
				if ($urandom_range(1)) send_byte(ChM);
				repeat ($urandom_range(4)) send_tick();
				k += 3;
			end else if (sel < 9) begin
				send_byte(8'($urandom));
				k++;
			end else begin
				send_tick();
				k++;
			end
		end
	endtask

	task automatic pause_for_results();
		in_valid <= 1'b0;
		while (expected_bytes.size() != 0) @(negedge clk);
	endtask

	initial begin
		int guard;
		errors = 0;
		n_items = 0;
		n_reports = 0;
		seq_len = 0;
		seq_waiting = 0;
		seq_ticks = 0;
		buttons = 0;
		timeout_ticks = TimeoutReset;
		foreach (seq_buf[i]) seq_buf[i] = 8'h00;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b1;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_plain_bytes();
		test_unknown_sequences();
		test_reports();
		test_short_and_timeout();

		test_random(70, 16'd2);
		pause_for_results();
		send_idle_pct = 48;
		test_random(70, 16'd1);
		send_idle_pct = 0;
		recv_stall_pct = 48;
		test_random(70, 16'd0);
		send_idle_pct = 19;
		recv_stall_pct = 19;
		test_random(70, 16'd5);

		in_valid <= 1'b0;
		guard = 0;
		while (expected_bytes.size() != 0 && guard < 200000) begin
			@(negedge clk);
			guard++;
		end
		repeat (50) @(negedge clk);
		if (expected_bytes.size() != 0) begin
			$error("%0d expected bytes never arrived", expected_bytes.size());
			errors++;
		end
		$display("covered %0d input transfers, %0d mouse reports, timeouts 0..65535",
			n_items, n_reports);
		if (errors == 0) $display("tb_top: clean");
		else $display("tb_top: errors");
		$finish;
	end

endmodule
